/* design/ptq_pkg.sv */
// Shared types, field widths and codes of the periodic task timer queue.
package ptq_pkg;

    // Pool size default and the limit on fired tasks per poll.
    localparam int MAX_TASKS_DEF = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);

    // Field widths of the command and result beats and of the tick counter.
    localparam int CMD_W    = 2;
    localparam int ID_W     = 8;
    localparam int DELAY_W  = 16;
    localparam int PERIOD_W = 16;
    localparam int KIND_W   = 2;
    localparam int TICK_W   = 64;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD  = 2'd0,
        CMD_DEL  = 2'd1,
        CMD_TICK = 2'd2,
        CMD_POLL = 2'd3
    } cmd_t;

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_ACK   = 2'd0,
        KIND_FIRED = 2'd1,
        KIND_EMPTY = 2'd2
    } kind_t;

    // Result status codes.
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FAIL = 1'b1;

    // Operations on the due-order line.
    typedef enum logic [1:0] {
        ORD_HOLD   = 2'd0,
        ORD_INSERT = 2'd1,
        ORD_POP    = 2'd2,
        ORD_ROTATE = 2'd3
    } ord_op_t;

endpackage

/* design/ptq_if.sv */
// Valid/ready channel interfaces for command beats and result beats.
interface ptq_in_if;
    import ptq_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [ID_W-1:0]     task_id;
    logic [DELAY_W-1:0]  first_delay;
    logic [PERIOD_W-1:0] repeat_period;

    modport source (output valid, cmd, task_id, first_delay, repeat_period, input ready);
    modport sink (input valid, cmd, task_id, first_delay, repeat_period, output ready);
endinterface

interface ptq_out_if;
    import ptq_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic              status;
    logic [ID_W-1:0]   fired_id;
    logic              last;

    modport source (output valid, kind, status, fired_id, last, input ready);
    modport sink (input valid, kind, status, fired_id, last, output ready);
endinterface

/* design/ptq_slot_mem.sv */
// Slot memory holding the due time and period of every task slot.
module ptq_slot_mem #(
    parameter int MAX_TASKS = ptq_pkg::MAX_TASKS_DEF,
    parameter int SW        = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic                          wr_per_en,
    input  logic [SW-1:0]                 wr_addr,
    input  logic [ptq_pkg::TICK_W-1:0]    wr_due,
    input  logic [ptq_pkg::PERIOD_W-1:0]  wr_per,
    input  logic [SW-1:0]                 rd_addr,
    output logic [ptq_pkg::TICK_W-1:0]    rd_due,
    output logic [ptq_pkg::PERIOD_W-1:0]  rd_per
);
    import ptq_pkg::*;

    logic [TICK_W-1:0]   due_mem [MAX_TASKS];
    logic [PERIOD_W-1:0] per_mem [MAX_TASKS];

    // Write port: the due time and, for a new task, its period.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            due_mem[wr_addr] <= wr_due;
        end
        if (wr_per_en)
        begin
            per_mem[wr_addr] <= wr_per;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_due <= due_mem[rd_addr];
        rd_per <= per_mem[rd_addr];
    end

endmodule

/* design/ptq_order.sv */
// Due-order line: slot indices and ids kept earliest due first.
module ptq_order #(
    parameter int MAX_TASKS = ptq_pkg::MAX_TASKS_DEF,
    parameter int SW        = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
    parameter int CW        = $clog2(MAX_TASKS + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ptq_pkg::ord_op_t         op,
    input  logic [CW-1:0]            pos,
    input  logic [SW-1:0]            new_slot,
    input  logic [ptq_pkg::ID_W-1:0] new_id,
    output logic [SW-1:0]            head_slot,
    output logic [ptq_pkg::ID_W-1:0] head_id,
    output logic [CW-1:0]            count
);
    import ptq_pkg::*;

    logic [SW-1:0]   slot_q [MAX_TASKS];
    logic [ID_W-1:0] id_q   [MAX_TASKS];
    logic [SW-1:0]   up_slot [MAX_TASKS];
    logic [ID_W-1:0] up_id   [MAX_TASKS];
    logic [SW-1:0]   dn_slot [MAX_TASKS];
    logic [ID_W-1:0] dn_id   [MAX_TASKS];
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [CW-1:0]   tail_idx;

    assign head_slot = slot_q[0];
    assign head_id   = id_q[0];
    assign count     = count_reg;
    assign tail_idx  = count_reg - 1'b1;

    // Neighbor taps of each entry.
    for (genvar g = 0; g < MAX_TASKS; g++)
    begin : g_tap
        if (g < MAX_TASKS - 1)
        begin : g_up
            assign up_slot[g] = slot_q[g+1];
            assign up_id[g]   = id_q[g+1];
        end
        else
        begin : g_up_end
            assign up_slot[g] = slot_q[g];
            assign up_id[g]   = id_q[g];
        end
        if (g > 0)
        begin : g_dn
            assign dn_slot[g] = slot_q[g-1];
            assign dn_id[g]   = id_q[g-1];
        end
        else
        begin : g_dn_end
            assign dn_slot[g] = slot_q[g];
            assign dn_id[g]   = id_q[g];
        end
    end

    // Each entry picks itself, a neighbor, the head or the new entry.
    for (genvar g = 0; g < MAX_TASKS; g++)
    begin : g_ent
        always_ff @(posedge clk)
        begin
            case (op)
                ORD_INSERT:
                begin
                    if (CW'(g) == pos)
                    begin
                        slot_q[g] <= new_slot;
                        id_q[g]   <= new_id;
                    end
                    else if (CW'(g) > pos)
                    begin
                        slot_q[g] <= dn_slot[g];
                        id_q[g]   <= dn_id[g];
                    end
                end
                ORD_POP:
                begin
                    slot_q[g] <= up_slot[g];
                    id_q[g]   <= up_id[g];
                end
                ORD_ROTATE:
                begin
                    if (CW'(g) == tail_idx)
                    begin
                        slot_q[g] <= slot_q[0];
                        id_q[g]   <= id_q[0];
                    end
                    else if (CW'(g) < tail_idx)
                    begin
                        slot_q[g] <= up_slot[g];
                        id_q[g]   <= up_id[g];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Live entry count.
    always_comb
    begin
        case (op)
            ORD_INSERT: count_next = count_reg + 1'b1;
            ORD_POP:    count_next = count_reg - 1'b1;
            default:    count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

/* design/ptq_alu.sv */
// Shared arithmetic unit: tick counter adder and unsigned due-time compare.
module ptq_alu (
    input  logic [ptq_pkg::TICK_W-1:0]   tick,
    input  logic [ptq_pkg::PERIOD_W-1:0] addend,
    input  logic [ptq_pkg::TICK_W-1:0]   cmp_a,
    input  logic [ptq_pkg::TICK_W-1:0]   cmp_b,
    output logic [ptq_pkg::TICK_W-1:0]   sum,
    output logic                         a_le_b
);
    import ptq_pkg::*;

    // Counter plus a 16-bit offset, wrapping modulo 2^64.
    assign sum = tick + TICK_W'(addend);

    // Plain unsigned compare of two due times.
    assign a_le_b = (cmp_a <= cmp_b);

endmodule

/* design/periodic_task_timer_queue.sv */
// Top level of the periodic task timer queue: command sequencer and result register.
//
// The in_ch channel takes command beats (add, delete, tick, poll); the out_ch
// channel gives result beats, the final one of each command marked by last.
// A command is taken only while the sequencer is idle; the block works on one
// command at a time. Add, unless the pool is full, scans all slots through the
// slot memory read port and the shared compare unit before it answers. Delete
// walks the due order once. Poll checks the head of the due order, emits each
// fired task, re-arms each periodic task that fires with another scan of all
// slots, and emits at most MAX_RESULTS tasks.
// Results leave through an output register, so the sequencer runs on while
// one result waits; it stalls only when it needs that register again and the
// receiver has not taken the waiting beat. Reset clears the tick counter, the
// slot used bits and the due order; slot contents are not cleared.
module periodic_task_timer_queue #(
    parameter int MAX_TASKS = ptq_pkg::MAX_TASKS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ptq_in_if.sink    in_ch,
    ptq_out_if.source out_ch
);
    import ptq_pkg::*;

    localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SCAN  = 9'b000000010,
        ST_INS   = 9'b000000100,
        ST_RESP  = 9'b000001000,
        ST_DEL   = 9'b000010000,
        ST_PHEAD = 9'b000100000,
        ST_PCHK  = 9'b001000000,
        ST_PEMIT = 9'b010000000,
        ST_PDONE = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [MAX_TASKS-1:0] used_reg, used_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [PERIOD_W-1:0] per_reg, per_next;
    logic [TICK_W-1:0]   new_due_reg, new_due_next;
    logic [CW-1:0]       pos_reg, pos_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [SW-1:0]       free_slot_reg, free_slot_next;
    logic                free_found_reg, free_found_next;
    logic                is_add_reg, is_add_next;
    logic                sv_reg, sv_next;
    logic [SW-1:0]       sidx_reg, sidx_next;
    logic                found_reg, found_next;
    logic                resp_status_reg, resp_status_next;
    logic [SW-1:0]       cur_slot_reg, cur_slot_next;
    logic [ID_W-1:0]     cur_id_reg, cur_id_next;
    logic [PERIOD_W-1:0] cur_per_reg, cur_per_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]     pend_id_reg, pend_id_next;
    logic [RES_CNT_W-1:0] nres_reg, nres_next;
    logic                out_valid_reg, out_valid_next;
    kind_t               out_kind_reg, out_kind_next;
    logic                out_status_reg, out_status_next;
    logic [ID_W-1:0]     out_id_reg, out_id_next;
    logic                out_last_reg, out_last_next;

    ord_op_t             ord_op;
    logic [SW-1:0]       ord_slot;
    logic [ID_W-1:0]     ord_id;
    logic [SW-1:0]       head_slot;
    logic [ID_W-1:0]     head_id;
    logic [CW-1:0]       ord_count;

    logic                mem_we, mem_per_we;
    logic [SW-1:0]       mem_waddr, mem_raddr;
    logic [TICK_W-1:0]   rd_due;
    logic [PERIOD_W-1:0] rd_per;

    logic [PERIOD_W-1:0] alu_addend;
    logic [TICK_W-1:0]   alu_cmp_b;
    logic [TICK_W-1:0]   alu_sum;
    logic                alu_le;

    logic                accept;
    logic                can_load;
    logic [SW-1:0]       ins_slot;

    ptq_order #(
        .MAX_TASKS (MAX_TASKS),
        .SW        (SW),
        .CW        (CW)
    ) u_order (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (ord_op),
        .pos       (pos_reg),
        .new_slot  (ord_slot),
        .new_id    (ord_id),
        .head_slot (head_slot),
        .head_id   (head_id),
        .count     (ord_count)
    );

    ptq_slot_mem #(
        .MAX_TASKS (MAX_TASKS),
        .SW        (SW)
    ) u_mem (
        .clk       (clk),
        .wr_en     (mem_we),
        .wr_per_en (mem_per_we),
        .wr_addr   (mem_waddr),
        .wr_due    (new_due_reg),
        .wr_per    (per_reg),
        .rd_addr   (mem_raddr),
        .rd_due    (rd_due),
        .rd_per    (rd_per)
    );

    ptq_alu u_alu (
        .tick   (tick_reg),
        .addend (alu_addend),
        .cmp_a  (rd_due),
        .cmp_b  (alu_cmp_b),
        .sum    (alu_sum),
        .a_le_b (alu_le)
    );

    // Channel handshakes.
    assign in_ch.ready     = (state_reg == ST_IDLE);
    assign accept          = in_ch.valid && in_ch.ready;
    assign can_load        = !out_valid_reg || out_ch.ready;
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.kind     = out_kind_reg;
    assign out_ch.status   = out_status_reg;
    assign out_ch.fired_id = out_id_reg;
    assign out_ch.last     = out_last_reg;

    // Operand selection for the shared unit.
    always_comb
    begin
        if (state_reg == ST_IDLE && in_ch.cmd == CMD_TICK)
        begin
            alu_addend = PERIOD_W'(1);
        end
        else if (state_reg == ST_IDLE)
        begin
            alu_addend = in_ch.first_delay;
        end
        else
        begin
            alu_addend = cur_per_reg;
        end
        alu_cmp_b = (state_reg == ST_PCHK) ? tick_reg : new_due_reg;
    end

    assign ins_slot  = is_add_reg ? free_slot_reg : cur_slot_reg;
    assign ord_slot  = ins_slot;
    assign ord_id    = is_add_reg ? id_reg : cur_id_reg;
    assign mem_waddr = ins_slot;

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        tick_next        = tick_reg;
        used_next        = used_reg;
        id_next          = id_reg;
        per_next         = per_reg;
        new_due_next     = new_due_reg;
        pos_next         = pos_reg;
        cnt_next         = cnt_reg;
        free_slot_next   = free_slot_reg;
        free_found_next  = free_found_reg;
        is_add_next      = is_add_reg;
        sv_next          = 1'b0;
        sidx_next        = sidx_reg;
        found_next       = found_reg;
        resp_status_next = resp_status_reg;
        cur_slot_next    = cur_slot_reg;
        cur_id_next      = cur_id_reg;
        cur_per_next     = cur_per_reg;
        pend_valid_next  = pend_valid_reg;
        pend_id_next     = pend_id_reg;
        nres_next        = nres_reg;
        out_valid_next   = out_valid_reg && !out_ch.ready;
        out_kind_next    = out_kind_reg;
        out_status_next  = out_status_reg;
        out_id_next      = out_id_reg;
        out_last_next    = out_last_reg;
        ord_op           = ORD_HOLD;
        mem_we           = 1'b0;
        mem_per_we       = 1'b0;
        mem_raddr        = cnt_reg[SW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_t'(in_ch.cmd))
                        CMD_ADD:
                        begin
                            if (ord_count == CW'(MAX_TASKS))
                            begin
                                resp_status_next = STAT_FAIL;
                                state_next       = ST_RESP;
                            end
                            else
                            begin
                                new_due_next    = alu_sum;
                                id_next         = in_ch.task_id;
                                per_next        = in_ch.repeat_period;
                                is_add_next     = 1'b1;
                                cnt_next        = '0;
                                pos_next        = '0;
                                free_found_next = 1'b0;
                                state_next      = ST_SCAN;
                            end
                        end
                        CMD_DEL:
                        begin
                            id_next    = in_ch.task_id;
                            cnt_next   = ord_count;
                            found_next = 1'b0;
                            state_next = ST_DEL;
                        end
                        CMD_TICK:
                        begin
                            tick_next        = alu_sum;
                            resp_status_next = STAT_OK;
                            state_next       = ST_RESP;
                        end
                        CMD_POLL:
                        begin
                            nres_next       = '0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_PHEAD;
                        end
                    endcase
                end
            end

            // Walk all slots: count live entries due no later than the new
            // due time and note the lowest free slot.
            ST_SCAN:
            begin
                if (sv_reg)
                begin
                    if (used_reg[sidx_reg] && (is_add_reg || sidx_reg != cur_slot_reg)
                        && alu_le)
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                    if (!used_reg[sidx_reg] && !free_found_reg)
                    begin
                        free_slot_next  = sidx_reg;
                        free_found_next = 1'b1;
                    end
                end
                if (cnt_reg != CW'(MAX_TASKS))
                begin
                    mem_raddr = cnt_reg[SW-1:0];
                    sidx_next = cnt_reg[SW-1:0];
                    sv_next   = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
                else if (!sv_reg)
                begin
                    state_next = ST_INS;
                end
            end

            // Place the entry in due order and store its due time and, for a new task, its period.
            ST_INS:
            begin
                ord_op               = ORD_INSERT;
                mem_we               = 1'b1;
                mem_per_we           = is_add_reg;
                used_next[ins_slot]  = 1'b1;
                if (is_add_reg)
                begin
                    resp_status_next = STAT_OK;
                    state_next       = ST_RESP;
                end
                else
                begin
                    state_next = ST_PHEAD;
                end
            end

            ST_RESP:
            begin
                if (can_load)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_ACK;
                    out_status_next = resp_status_reg;
                    out_id_next     = '0;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            // One full turn of the order line; the first match is dropped.
            ST_DEL:
            begin
                if (cnt_reg == '0)
                begin
                    resp_status_next = found_reg ? STAT_OK : STAT_FAIL;
                    state_next       = ST_RESP;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (!found_reg && head_id == id_reg)
                    begin
                        ord_op               = ORD_POP;
                        used_next[head_slot] = 1'b0;
                        found_next           = 1'b1;
                    end
                    else
                    begin
                        ord_op = ORD_ROTATE;
                    end
                end
            end

            ST_PHEAD:
            begin
                if (ord_count == '0 || nres_reg == RES_CNT_W'(MAX_RESULTS))
                begin
                    state_next = ST_PDONE;
                end
                else
                begin
                    mem_raddr  = head_slot;
                    state_next = ST_PCHK;
                end
            end

            // The head fires when its due time is not after the counter.
            ST_PCHK:
            begin
                if (!alu_le)
                begin
                    state_next = ST_PDONE;
                end
                else
                begin
                    cur_slot_next = head_slot;
                    cur_id_next   = head_id;
                    cur_per_next  = rd_per;
                    ord_op        = ORD_POP;
                    nres_next     = nres_reg + 1'b1;
                    state_next    = ST_PEMIT;
                end
            end

            // Send the previous fired task, then re-arm or free this one.
            ST_PEMIT:
            begin
                if (!pend_valid_reg || can_load)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = KIND_FIRED;
                        out_status_next = STAT_OK;
                        out_id_next     = pend_id_reg;
                        out_last_next   = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_id_next    = cur_id_reg;
                    if (cur_per_reg != '0)
                    begin
                        new_due_next = alu_sum;
                        is_add_next  = 1'b0;
                        cnt_next     = '0;
                        pos_next     = '0;
                        state_next   = ST_SCAN;
                    end
                    else
                    begin
                        used_next[cur_slot_reg] = 1'b0;
                        state_next              = ST_PHEAD;
                    end
                end
            end

            ST_PDONE:
            begin
                if (can_load)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = pend_valid_reg ? KIND_FIRED : KIND_EMPTY;
                    out_status_next = STAT_OK;
                    out_id_next     = pend_valid_reg ? pend_id_reg : '0;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            tick_reg        <= '0;
            used_reg        <= '0;
            id_reg          <= '0;
            per_reg         <= '0;
            new_due_reg     <= '0;
            pos_reg         <= '0;
            cnt_reg         <= '0;
            free_slot_reg   <= '0;
            free_found_reg  <= 1'b0;
            is_add_reg      <= 1'b0;
            sv_reg          <= 1'b0;
            sidx_reg        <= '0;
            found_reg       <= 1'b0;
            resp_status_reg <= STAT_OK;
            cur_slot_reg    <= '0;
            cur_id_reg      <= '0;
            cur_per_reg     <= '0;
            pend_valid_reg  <= 1'b0;
            pend_id_reg     <= '0;
            nres_reg        <= '0;
            out_valid_reg   <= 1'b0;
            out_kind_reg    <= KIND_ACK;
            out_status_reg  <= STAT_OK;
            out_id_reg      <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            tick_reg        <= tick_next;
            used_reg        <= used_next;
            id_reg          <= id_next;
            per_reg         <= per_next;
            new_due_reg     <= new_due_next;
            pos_reg         <= pos_next;
            cnt_reg         <= cnt_next;
            free_slot_reg   <= free_slot_next;
            free_found_reg  <= free_found_next;
            is_add_reg      <= is_add_next;
            sv_reg          <= sv_next;
            sidx_reg        <= sidx_next;
            found_reg       <= found_next;
            resp_status_reg <= resp_status_next;
            cur_slot_reg    <= cur_slot_next;
            cur_id_reg      <= cur_id_next;
            cur_per_reg     <= cur_per_next;
            pend_valid_reg  <= pend_valid_next;
            pend_id_reg     <= pend_id_next;
            nres_reg        <= nres_next;
            out_valid_reg   <= out_valid_next;
            out_kind_reg    <= out_kind_next;
            out_status_reg  <= out_status_next;
            out_id_reg      <= out_id_next;
            out_last_reg    <= out_last_next;
        end
    end

    // Between commands the number of used slots equals the due order's entry count.
    a_used_matches_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ($countones(used_reg) == int'(ord_count)))
        else $error("used slots and due order disagree");

    // An insert never happens into a full order line.
    a_insert_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS) |-> (ord_count < CW'(MAX_TASKS)))
        else $error("insert into full due order");

    // A tick command advances the counter by exactly one.
    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.cmd == CMD_TICK) |=> (tick_reg == $past(tick_reg) + 1'b1))
        else $error("tick counter did not advance by one");

endmodule

/* tb/periodic_task_timer_queue_tb.sv */
// Self-checking testbench of the periodic task timer queue: directed and random commands.
`timescale 1ns / 1ps

module periodic_task_timer_queue_tb;
    import ptq_pkg::*;

    localparam int POOL_SIZE   = MAX_TASKS_DEF;
    localparam int CYCLE_LIMIT = 800000;
    localparam int RX_HOLD_LEN = 300;
    localparam int SETTLE_LEN  = 64;
    localparam int PHASE_LEN   = 88;

    // One command beat as queued for the driver.
    typedef struct {
        cmd_t                cmd;
        logic [ID_W-1:0]     id;
        logic [DELAY_W-1:0]  delay;
        logic [PERIOD_W-1:0] period;
        int                  phase;
        bit                  drain;
        bit                  hold_rx;
    } timer_cmd_t;

    // One result beat as the timer queue should produce it.
    typedef struct {
        kind_t           kind;
        logic            status;
        logic [ID_W-1:0] fired_id;
        logic            last;
    } timer_res_t;

    logic clk = 1'b0;
    logic rst_n;

    ptq_in_if  in_ch ();
    ptq_out_if out_ch ();

    periodic_task_timer_queue dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #1 clk = ~clk;

    // Per-phase idle rates: sender idle and receiver stall, in percent.
    int sender_idle_pct [4] = '{0, 51, 0, 10};
    int rx_stall_pct    [4] = '{0, 0, 51, 10};

    timer_cmd_t cmd_backlog[$];
    timer_res_t awaited_results[$];
    timer_cmd_t cur_cmd;
    int         cur_phase;
    int         error_count;
    int         rx_hold_cnt;
    logic       rx_hold_go;
    int         cycle_cnt;

    // Shadow of the timer pool.
    logic [TICK_W-1:0]   shadow_tick;
    logic                shadow_used   [POOL_SIZE];
    logic [ID_W-1:0]     shadow_id     [POOL_SIZE];
    logic [TICK_W-1:0]   shadow_due    [POOL_SIZE];
    logic [PERIOD_W-1:0] shadow_period [POOL_SIZE];
    int                  shadow_order[$];

    task automatic flag_mismatch(input string msg);
        begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
            error_count++;
        end
    endtask

    // Put a slot into the due order behind every entry due no later than it.
    function automatic void place_by_due(input int s);
        int pos;
        begin
            pos = 0;
            while (pos < shadow_order.size() && !(shadow_due[s] < shadow_due[shadow_order[pos]]))
                pos++;
            shadow_order.insert(pos, s);
        end
    endfunction

    function automatic timer_res_t make_res(input kind_t k, input logic st,
                                            input logic [ID_W-1:0] fid, input logic lst);
        timer_res_t r;
        begin
            r.kind     = k;
            r.status   = st;
            r.fired_id = fid;
            r.last     = lst;
            return r;
        end
    endfunction

    // Apply one accepted command to the shadow pool and queue its results.
    task automatic run_timer_cmd(input timer_cmd_t c);
        int         s;
        int         n;
        bit         found;
        timer_res_t fired[$];
        begin
            case (c.cmd)
                CMD_ADD:
                begin
                    s = POOL_SIZE;
                    for (int i = POOL_SIZE - 1; i >= 0; i--)
                        if (!shadow_used[i])
                            s = i;
                    if (s == POOL_SIZE)
                        awaited_results.push_back(make_res(KIND_ACK, STAT_FAIL, '0, 1'b1));
                    else
                    begin
                        shadow_used[s]   = 1'b1;
                        shadow_id[s]     = c.id;
                        shadow_period[s] = c.period;
                        shadow_due[s]    = shadow_tick + TICK_W'(c.delay);
                        place_by_due(s);
                        awaited_results.push_back(make_res(KIND_ACK, STAT_OK, '0, 1'b1));
                    end
                end
                CMD_DEL:
                begin
                    found = 1'b0;
                    for (int i = 0; i < shadow_order.size(); i++)
                    begin
                        if (!found && shadow_id[shadow_order[i]] == c.id)
                        begin
                            found = 1'b1;
                            shadow_used[shadow_order[i]] = 1'b0;
                            shadow_order.delete(i);
                        end
                    end
                    awaited_results.push_back(make_res(KIND_ACK, found ? STAT_OK : STAT_FAIL,
                                                       '0, 1'b1));
                end
                CMD_TICK:
                begin
                    shadow_tick = shadow_tick + 1;
                    awaited_results.push_back(make_res(KIND_ACK, STAT_OK, '0, 1'b1));
                end
                default:
                begin
                    // Poll: fire due tasks from the head, re-arming periodic ones.
                    n = 0;
                    while (shadow_order.size() > 0 && n < MAX_RESULTS)
                    begin
                        s = shadow_order[0];
                        if (shadow_tick < shadow_due[s])
                            break;
                        void'(shadow_order.pop_front());
                        fired.push_back(make_res(KIND_FIRED, STAT_OK, shadow_id[s], 1'b0));
                        n++;
                        if (shadow_period[s] != '0)
                        begin
                            shadow_due[s] = shadow_tick + TICK_W'(shadow_period[s]);
                            place_by_due(s);
                        end
                        else
                            shadow_used[s] = 1'b0;
                    end
                    if (n == 0)
                        awaited_results.push_back(make_res(KIND_EMPTY, STAT_OK, '0, 1'b1));
                    else
                    begin
                        for (int i = 0; i < n; i++)
                        begin
                            if (i == n - 1)
                                fired[i].last = 1'b1;
                            awaited_results.push_back(fired[i]);
                        end
                    end
                end
            endcase
        end
    endtask

    task automatic queue_cmd(input cmd_t cmd, input logic [ID_W-1:0] id,
                             input logic [DELAY_W-1:0] delay, input logic [PERIOD_W-1:0] period,
                             input int phase, input bit drain, input bit hold_rx);
        timer_cmd_t c;
        begin
            c.cmd     = cmd;
            c.id      = id;
            c.delay   = delay;
            c.period  = period;
            c.phase   = phase;
            c.drain   = drain;
            c.hold_rx = hold_rx;
            cmd_backlog.push_back(c);
        end
    endtask

    // Random command: ids mostly from a narrow range so deletes find their tasks.
    task automatic queue_random_cmd(input int phase, input bit drain, input bit hold_rx);
        int                  r;
        cmd_t                cmd;
        logic [ID_W-1:0]     id;
        logic [DELAY_W-1:0]  delay;
        logic [PERIOD_W-1:0] period;
        begin
            r = $urandom_range(99);
            if (r < 30)
                cmd = CMD_ADD;
            else if (r < 48)
                cmd = CMD_DEL;
            else if (r < 78)
                cmd = CMD_TICK;
            else
                cmd = CMD_POLL;
            id = ($urandom_range(99) < 80) ? ID_W'($urandom_range(15)) : ID_W'($urandom);
            r = $urandom_range(99);
            if (r < 85)
                delay = DELAY_W'($urandom_range(6));
            else
                delay = DELAY_W'($urandom);
            r = $urandom_range(99);
            if (r < 40)
                period = '0;
            else if (r < 85)
                period = PERIOD_W'($urandom_range(8, 1));
            else
                period = PERIOD_W'($urandom);
            queue_cmd(cmd, id, delay, period, phase, drain, hold_rx);
        end
    endtask

    // Receiver hold-off, counted down in cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rx_hold_cnt <= 0;
        else if (rx_hold_go)
            rx_hold_cnt <= RX_HOLD_LEN;
        else if (rx_hold_cnt > 0)
            rx_hold_cnt <= rx_hold_cnt - 1;
    end

    // Command driver: predict on each accepted beat, then offer the next one.
    always @(posedge clk or negedge rst_n)
    begin
        bit offer;
        timer_cmd_t nxt;
        if (!rst_n)
        begin
            in_ch.valid         <= 1'b0;
            in_ch.cmd           <= CMD_TICK;
            in_ch.task_id       <= '0;
            in_ch.first_delay   <= '0;
            in_ch.repeat_period <= '0;
            rx_hold_go          <= 1'b0;
        end
        else
        begin
            offer = 1'b0;
            if (in_ch.valid && in_ch.ready)
                run_timer_cmd(cur_cmd);
            if (in_ch.valid && !in_ch.ready)
            begin
                offer = 1'b1;
                rx_hold_go <= 1'b0;
            end
            else if (cmd_backlog.size() > 0)
            begin
                nxt = cmd_backlog[0];
                if (!(nxt.drain && awaited_results.size() != 0) &&
                    $urandom_range(99) >= sender_idle_pct[nxt.phase])
                begin
                    void'(cmd_backlog.pop_front());
                    cur_cmd   <= nxt;
                    cur_phase <= nxt.phase;
                    in_ch.cmd           <= nxt.cmd;
                    in_ch.task_id       <= nxt.id;
                    in_ch.first_delay   <= nxt.delay;
                    in_ch.repeat_period <= nxt.period;
                    offer = 1'b1;
                    rx_hold_go <= nxt.hold_rx;
                end
                else
                    rx_hold_go <= 1'b0;
            end
            else
                rx_hold_go <= 1'b0;
            in_ch.valid <= offer;
        end
    end

    // Result monitor: compare each accepted beat with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        timer_res_t want;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (awaited_results.size() == 0)
                    flag_mismatch("result beat with nothing awaited");
                else
                begin
                    want = awaited_results.pop_front();
                    if (out_ch.kind !== want.kind)
                        flag_mismatch($sformatf("kind got %0d want %0d", out_ch.kind, want.kind));
                    if (out_ch.status !== want.status)
                        flag_mismatch($sformatf("status got %0b want %0b",
                                                out_ch.status, want.status));
                    if (out_ch.fired_id !== want.fired_id)
                        flag_mismatch($sformatf("fired_id got %0h want %0h",
                                                out_ch.fired_id, want.fired_id));
                    if (out_ch.last !== want.last)
                        flag_mismatch($sformatf("last got %0b want %0b", out_ch.last, want.last));
                end
            end
            out_ch.ready <= (rx_hold_cnt == 0) && ($urandom_range(99) >= rx_stall_pct[cur_phase]);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        cycle_cnt           = 0;
        error_count         = 0;
        cur_phase           = 0;
        in_ch.valid         = 1'b0;
        in_ch.cmd           = CMD_TICK;
        in_ch.task_id       = '0;
        in_ch.first_delay   = '0;
        in_ch.repeat_period = '0;
        out_ch.ready        = 1'b0;
        rx_hold_go          = 1'b0;
        shadow_tick         = '0;
        for (int i = 0; i < POOL_SIZE; i++)
            shadow_used[i] = 1'b0;

        // Directed: extremes, zero delay, duplicates, missing id, full pool.
        queue_cmd(CMD_ADD, 8'h00, 16'h0000, 16'h0000, 0, 1'b0, 1'b0);
        queue_cmd(CMD_ADD, 8'hFF, 16'hFFFF, 16'hFFFF, 0, 1'b0, 1'b0);
        queue_cmd(CMD_POLL, 8'h00, 16'h0000, 16'h0000, 0, 1'b0, 1'b0);
        queue_cmd(CMD_POLL, 8'hFF, 16'hFFFF, 16'hFFFF, 0, 1'b0, 1'b0);
        queue_cmd(CMD_ADD, 8'h55, 16'h0001, 16'h0002, 0, 1'b0, 1'b0);
        queue_cmd(CMD_ADD, 8'h55, 16'h0001, 16'h0000, 0, 1'b0, 1'b0);
        queue_cmd(CMD_ADD, 8'hAA, 16'h0000, 16'h0001, 0, 1'b0, 1'b0);
        queue_cmd(CMD_TICK, 8'h00, 16'h0000, 16'h0000, 0, 1'b0, 1'b0);
        queue_cmd(CMD_POLL, 8'h00, 16'h0000, 16'h0000, 0, 1'b0, 1'b0);
        queue_cmd(CMD_DEL, 8'h55, 16'h0000, 16'h0000, 0, 1'b0, 1'b0);
        queue_cmd(CMD_DEL, 8'h55, 16'h0000, 16'h0000, 0, 1'b0, 1'b0);
        queue_cmd(CMD_TICK, 8'h00, 16'h0000, 16'h0000, 0, 1'b0, 1'b0);
        queue_cmd(CMD_POLL, 8'h00, 16'h0000, 16'h0000, 0, 1'b0, 1'b0);
        for (int i = 1; i <= POOL_SIZE - 1; i++)
            queue_cmd(CMD_ADD, ID_W'(i), DELAY_W'(i % 5), '0, 0, 1'b0, 1'b0);
        queue_cmd(CMD_DEL, 8'hFF, 16'h0000, 16'h0000, 0, 1'b0, 1'b0);
        queue_cmd(CMD_DEL, 8'hAA, 16'h0000, 16'h0000, 0, 1'b0, 1'b0);

        // Random phases; each later phase starts from a drained queue.
        for (int ph = 0; ph < 4; ph++)
            for (int k = 0; k < PHASE_LEN; k++)
                queue_random_cmd(ph, (ph > 0 && k == 0), (ph == 2 && k == 0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || in_ch.valid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_LEN) @(posedge clk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
design/ptq_pkg.sv
design/ptq_if.sv
design/ptq_slot_mem.sv
design/ptq_order.sv
design/ptq_alu.sv
design/periodic_task_timer_queue.sv
tb/periodic_task_timer_queue_tb.sv
